// ===== hw/rtl/threshold_select_quintic_blend_macros.svh =====
// Assertion macros shared by the threshold select blend RTL.
`ifndef THRESHOLD_SELECT_QUINTIC_BLEND_MACROS_SVH
`define THRESHOLD_SELECT_QUINTIC_BLEND_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define THSQ_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define THSQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/thsq_pkg.sv =====
// Types and constants for the threshold select quintic blend block.
package thsq_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 12;
    localparam int FALLOFF_BITS  = SAMPLE_BITS - 1;

    // blend fraction runs 0..ONE inclusive
    localparam int T_BITS    = FRACTION_BITS + 1;
    localparam int TT_BITS   = 2 * T_BITS;
    localparam int Q_BITS    = FRACTION_BITS + 4;
    localparam int QS_BITS   = FRACTION_BITS + 6;
    localparam int SQ_BITS   = T_BITS + Q_BITS;
    localparam int BAND_BITS = SAMPLE_BITS + 2;
    localparam int DEN_BITS  = SAMPLE_BITS;
    localparam int NUM_BITS  = SAMPLE_BITS + FRACTION_BITS + 2;
    localparam int PROD_BITS = SAMPLE_BITS + T_BITS + 1;

    localparam int unsigned FX_ONE  = 1 << FRACTION_BITS;
    localparam int unsigned FX_HALF = 1 << (FRACTION_BITS - 1);

    localparam int IN_DATA_BITS  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FALLOFF   = 1'd1;

    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_HIGH,
        SEL_BLEND
    } sel_t;

    // what rides alongside the fraction through the pipeline
    typedef struct packed {
        sel_t                          sel;
        logic signed [SAMPLE_BITS-1:0] low;
        logic signed [SAMPLE_BITS-1:0] high;
    } side_t;

endpackage

// ===== hw/rtl/thsq_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, elastic stalls.
module thsq_div
    import thsq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    input  side_t               side_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [T_BITS-1:0]   quo,
    output side_t               side_out
);

    localparam int LAST = T_BITS - 1;

    logic                valid_reg [T_BITS];
    logic [NUM_BITS-1:0] rem_reg   [T_BITS];
    logic [T_BITS-1:0]   quo_reg   [T_BITS];
    side_t               side_reg  [T_BITS];

    logic [NUM_BITS-1:0] rem_next  [T_BITS];
    logic [T_BITS-1:0]   quo_next  [T_BITS];
    logic                en        [T_BITS];

    logic [NUM_BITS-1:0] den_ext;

    assign den_ext = {{(NUM_BITS - DEN_BITS){1'b0}}, den};

    genvar k;
    generate
        for (k = 0; k < T_BITS; k++) begin : g_stage
            localparam int BIT = LAST - k;

            logic [NUM_BITS-1:0] rem_in;
            logic [T_BITS-1:0]   quo_in;
            logic                valid_in;
            side_t               side_in_k;
            logic [NUM_BITS-1:0] shifted;

            if (k == 0) begin : g_first
                assign rem_in    = num;
                assign quo_in    = '0;
                assign valid_in  = in_valid;
                assign side_in_k = side_in;
            end else begin : g_rest
                assign rem_in    = rem_reg[k-1];
                assign quo_in    = quo_reg[k-1];
                assign valid_in  = valid_reg[k-1];
                assign side_in_k = side_reg[k-1];
            end

            if (k == LAST) begin : g_en_last
                assign en[k] = !valid_reg[k] || out_ready;
            end else begin : g_en_mid
                assign en[k] = !valid_reg[k] || en[k+1];
            end

            assign shifted = den_ext << BIT;

            always_comb
            begin
                if (rem_in >= shifted)
                begin
                    rem_next[k] = rem_in - shifted;
                    quo_next[k] = quo_in | (T_BITS'(1) << BIT);
                end
                else
                begin
                    rem_next[k] = rem_in;
                    quo_next[k] = quo_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k] && valid_in)
                begin
                    rem_reg[k]  <= rem_next[k];
                    quo_reg[k]  <= quo_next[k];
                    side_reg[k] <= side_in_k;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = valid_reg[LAST];
    assign quo       = quo_reg[LAST];
    assign side_out  = side_reg[LAST];

`include "threshold_select_quintic_blend_macros.svh"

    `THSQ_ASSERT_NEXT(a_div_hold, valid_reg[LAST] && !out_ready, valid_reg[LAST] && $stable(quo_reg[LAST]))
    `THSQ_ASSERT_NOW(a_div_first_free, !valid_reg[0], in_ready)
    `THSQ_ASSERT_NEXT(a_div_no_loss, valid_reg[0] && !en[0], valid_reg[0])

endmodule

// ===== hw/rtl/threshold_select_quintic_blend.sv =====
// Threshold select with quintic crossfade: top level and blend pipeline.
// Pipeline: 1 band stage, 13 divider stages, 5 fade and blend stages.
// Throughput: one pixel per cycle while m_tready holds; every stage stalls on its own, so
// bubbles close up while the output waits.
// Reset clears all valid bits and sets threshold and falloff to zero.
module threshold_select_quintic_blend
    import thsq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,   // control_sample, low_sample, high_sample
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata    // result_sample
);

    // configuration
    logic signed [SAMPLE_BITS-1:0] threshold_reg;
    logic        [FALLOFF_BITS-1:0] falloff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            falloff_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[SAMPLE_BITS-1:0];
                REG_FALLOFF:   falloff_reg   <= cfg_data[FALLOFF_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // band stage: classify and form the divider numerator
    logic signed [SAMPLE_BITS-1:0] ctrl_in, low_in, high_in;
    logic signed [BAND_BITS-1:0]   ctrl_ext, th_ext, f_ext, lower, upper, band_pos;
    sel_t                          sel_in;
    logic [NUM_BITS-1:0]           num_in;

    assign ctrl_in = s_tdata[SAMPLE_BITS-1:0];
    assign low_in  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign high_in = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    assign ctrl_ext = BAND_BITS'(ctrl_in);
    assign th_ext   = BAND_BITS'(threshold_reg);
    assign f_ext    = $signed({{(BAND_BITS - FALLOFF_BITS){1'b0}}, falloff_reg});
    assign lower    = th_ext - f_ext;
    assign upper    = th_ext + f_ext;
    assign band_pos = ctrl_ext - lower;

    always_comb
    begin
        num_in = '0;
        if (falloff_reg == '0)
        begin
            sel_in = (ctrl_ext < th_ext) ? SEL_LOW : SEL_HIGH;
        end
        else if (ctrl_ext < lower)
        begin
            sel_in = SEL_LOW;
        end
        else if (ctrl_ext > upper)
        begin
            sel_in = SEL_HIGH;
        end
        else
        begin
            sel_in = SEL_BLEND;
            num_in = ({{(NUM_BITS - SAMPLE_BITS - 1){1'b0}}, band_pos[SAMPLE_BITS:0]}
                      << FRACTION_BITS)
                     + {{(NUM_BITS - FALLOFF_BITS){1'b0}}, falloff_reg};
        end
    end

    logic                a_valid_reg;
    logic [NUM_BITS-1:0] a_num_reg;
    side_t               a_side_reg;
    logic                a_en;
    logic                div_in_ready;

    assign a_en     = !a_valid_reg || div_in_ready;
    assign s_tready = a_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_en)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && s_tvalid)
        begin
            a_num_reg       <= num_in;
            a_side_reg.sel  <= sel_in;
            a_side_reg.low  <= low_in;
            a_side_reg.high <= high_in;
        end
    end

    // fraction t = (num) / (2 * falloff)
    logic              div_valid;
    logic [T_BITS-1:0] div_quo;
    side_t             div_side;
    logic              b_en;

    thsq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (div_in_ready),
        .num       (a_num_reg),
        .den       ({falloff_reg, 1'b0}),
        .side_in   (a_side_reg),
        .out_valid (div_valid),
        .out_ready (b_en),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    // stage B: clamp t, square it
    logic              b_valid_reg;
    logic [T_BITS-1:0] b_t_reg, b_t2_reg;
    side_t             b_side_reg;
    logic [T_BITS-1:0] t_next;
    logic [TT_BITS-1:0] tt_prod, tt_round;
    logic              c_en;

    assign t_next   = (div_quo > T_BITS'(FX_ONE)) ? T_BITS'(FX_ONE) : div_quo;
    assign tt_prod  = {{(TT_BITS - T_BITS){1'b0}}, t_next}
                    * {{(TT_BITS - T_BITS){1'b0}}, t_next};
    assign tt_round = (tt_prod + TT_BITS'(FX_HALF)) >> FRACTION_BITS;
    assign b_en     = !b_valid_reg || c_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            b_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en && div_valid)
        begin
            b_t_reg    <= t_next;
            b_t2_reg   <= tt_round[T_BITS-1:0];
            b_side_reg <= div_side;
        end
    end

    // stage C: cube and the quadratic factor 6t^2 - 15t + 10
    logic              c_valid_reg;
    logic [T_BITS-1:0] c_t3_reg;
    logic [Q_BITS-1:0] c_q_reg;
    side_t             c_side_reg;
    logic [TT_BITS-1:0] t3_prod, t3_round;
    logic [QS_BITS-1:0] q_pos, q_neg, q_diff;
    logic [Q_BITS-1:0]  q_next;
    logic              d_en;

    assign t3_prod  = {{(TT_BITS - T_BITS){1'b0}}, b_t2_reg}
                    * {{(TT_BITS - T_BITS){1'b0}}, b_t_reg};
    assign t3_round = (t3_prod + TT_BITS'(FX_HALF)) >> FRACTION_BITS;
    assign q_pos    = {{(QS_BITS - T_BITS){1'b0}}, b_t2_reg} * QS_BITS'(6)
                    + QS_BITS'(10 * FX_ONE);
    assign q_neg    = {{(QS_BITS - T_BITS){1'b0}}, b_t_reg} * QS_BITS'(15);
    assign q_diff   = q_pos - q_neg;
    assign q_next   = (q_pos > q_neg) ? q_diff[Q_BITS-1:0] : '0;
    assign c_en     = !c_valid_reg || d_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en && b_valid_reg)
        begin
            c_t3_reg   <= t3_round[T_BITS-1:0];
            c_q_reg    <= q_next;
            c_side_reg <= b_side_reg;
        end
    end

    // stage D: fade s = t^3 * q, clamped to one
    logic              d_valid_reg;
    logic [T_BITS-1:0] d_s_reg;
    side_t             d_side_reg;
    logic [SQ_BITS-1:0] s_prod, s_round;
    logic [T_BITS-1:0]  s_next;
    logic              e_en;

    assign s_prod  = {{(SQ_BITS - T_BITS){1'b0}}, c_t3_reg}
                   * {{(SQ_BITS - Q_BITS){1'b0}}, c_q_reg};
    assign s_round = (s_prod + SQ_BITS'(FX_HALF)) >> FRACTION_BITS;
    assign s_next  = (s_round > SQ_BITS'(FX_ONE)) ? T_BITS'(FX_ONE) : s_round[T_BITS-1:0];
    assign d_en    = !d_valid_reg || e_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_en && c_valid_reg)
        begin
            d_s_reg    <= s_next;
            d_side_reg <= c_side_reg;
        end
    end

    // stage E: (high - low) * s
    logic                        e_valid_reg;
    logic signed [PROD_BITS-1:0] e_prod_reg;
    side_t                       e_side_reg;
    logic signed [SAMPLE_BITS:0] span;
    logic signed [PROD_BITS-1:0] span_ext, s_ext;
    logic                        f_en;

    assign span     = $signed({d_side_reg.high[SAMPLE_BITS-1], d_side_reg.high})
                    - $signed({d_side_reg.low[SAMPLE_BITS-1], d_side_reg.low});
    assign span_ext = PROD_BITS'(span);
    assign s_ext    = $signed({{(PROD_BITS - T_BITS){1'b0}}, d_s_reg});
    assign e_en     = !e_valid_reg || f_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (e_en)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_en && d_valid_reg)
        begin
            e_prod_reg <= span_ext * s_ext;
            e_side_reg <= d_side_reg;
        end
    end

    // stage F: round, add low, or pass a candidate straight through
    logic                          f_valid_reg;
    logic [SAMPLE_BITS-1:0]        f_result_reg;
    logic signed [PROD_BITS-1:0]   blend_round;
    logic [SAMPLE_BITS-1:0]        result_next;

    assign blend_round = (e_prod_reg + $signed(PROD_BITS'(FX_HALF))) >>> FRACTION_BITS;
    assign f_en        = !f_valid_reg || m_tready;

    always_comb
    begin
        case (e_side_reg.sel)
            SEL_LOW:   result_next = e_side_reg.low;
            SEL_HIGH:  result_next = e_side_reg.high;
            SEL_BLEND: result_next = e_side_reg.low + blend_round[SAMPLE_BITS-1:0];
            default:   result_next = e_side_reg.low;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (f_en)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en && e_valid_reg)
        begin
            f_result_reg <= result_next;
        end
    end

    assign m_tvalid = f_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(f_result_reg);

`include "threshold_select_quintic_blend_macros.svh"

    `THSQ_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
    `THSQ_ASSERT_NEXT(a_low_passes,
        f_en && e_valid_reg && (e_side_reg.sel == SEL_LOW),
        m_tdata[SAMPLE_BITS-1:0] == $past(e_side_reg.low))
    `THSQ_ASSERT_NOW(a_fade_bounded, d_valid_reg, d_s_reg <= T_BITS'(FX_ONE))

endmodule
